/* rtl/npp_pkg.sv */
// Shared constants, payload types and sequencer states for the nearest point on polyline block.
// Has no dependencies. Every other file of the block depends on it.
`timescale 1ns / 1ps

package npp_pkg;

  // Fixed point formats
  localparam int FRAC_BITS = 12;
  localparam int T_BITS    = 30;
  localparam int ALONG_W   = 44;
  localparam int DIR_MAX   = 32767;

  // A segment is skipped when len2 * 10^6 < 2^(2*FRAC_BITS), that is len2 below this bound
  localparam longint unsigned SHORT_LEN2_LIM =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;

  // Serial multiplier: operand magnitudes up to 34 bits
  localparam int MUL_W     = 34;
  localparam int MUL_CNT_W = $clog2(MUL_W + 1);

  // Serial square root: radicand up to 68 bits, root of 34 bits
  localparam int SQ_RAD_W  = 68;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 3;
  localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

  // Serial divider: divisor up to 66 bits, numerator bits shifted in one per step
  localparam int DIV_DEN_W     = 66;
  localparam int DIV_NUM_W     = 48;
  localparam int DIV_CNT_W     = $clog2(DIV_NUM_W + 1);
  localparam int DIV_T_STEPS   = T_BITS;
  localparam int DIV_DIR_STEPS = DIV_NUM_W;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_height;
    logic               last_vertex;
  } npp_req_t;

  typedef struct packed {
    logic               found;
    logic        [31:0] distance;
    logic [ALONG_W-1:0] along;
    logic signed [31:0] height;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_z;
  } npp_res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LEN_X,
    S_LEN_Z,
    S_SQRT_LEN,
    S_DOT_X,
    S_DOT_Z,
    S_DIV_T,
    S_OFF_X,
    S_OFF_Z,
    S_ERR_X,
    S_ERR_Z,
    S_SQRT_D,
    S_ALONG,
    S_HGT,
    S_DIR_X,
    S_DIR_Z,
    S_FINISH,
    S_EMIT
  } npp_state_e;

endpackage

/* rtl/npp_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on npp_pkg for the payload types.
`timescale 1ns / 1ps

interface npp_req_if;
  logic              valid;
  logic              ready;
  npp_pkg::npp_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface npp_res_if;
  logic              valid;
  logic              ready;
  npp_pkg::npp_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/npp_mul.sv */
// Bit-serial unsigned multiplier, one multiplier bit per cycle, MSB first.
// Depends on npp_pkg for the operand width.
`timescale 1ns / 1ps

module npp_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [npp_pkg::MUL_W-1:0]    a_i,
  input  logic [npp_pkg::MUL_W-1:0]    b_i,
  output logic                         done_o,
  output logic [2*npp_pkg::MUL_W-1:0]  prod_o
);
  import npp_pkg::*;

  logic [MUL_W-1:0]     a_q, b_q;
  logic [2*MUL_W-1:0]   acc_q, acc_d;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 run_q, done_q;

  // Shift the partial product and add the multiplicand for a set bit
  assign acc_d = {acc_q[2*MUL_W-2:0], 1'b0} + (b_q[MUL_W-1] ? {{MUL_W{1'b0}}, a_q} : '0);

  // Count the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= MUL_CNT_W'(MUL_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operands and accumulate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      b_q   <= {b_q[MUL_W-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/npp_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits and one root bit per cycle.
// Depends on npp_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module npp_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [npp_pkg::SQ_RAD_W-1:0]   rad_i,
  output logic                           done_o,
  output logic [npp_pkg::SQ_ROOT_W-1:0]  root_o
);
  import npp_pkg::*;

  logic [SQ_RAD_W-1:0]  rad_q;
  logic [SQ_REM_W-1:0]  rem_q, rem_sh, trial;
  logic [SQ_ROOT_W-1:0] root_q;
  logic [SQ_CNT_W-1:0]  cnt_q;
  logic                 run_q, done_q;

  // Bring down two radicand bits and try root bit one
  assign rem_sh = {rem_q[SQ_REM_W-3:0], rad_q[SQ_RAD_W-1:SQ_RAD_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= SQ_CNT_W'(SQ_ROOT_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SQ_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q <= {rad_q[SQ_RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/npp_div.sv */
// Restoring divider, one quotient bit per cycle, with a preset partial remainder.
// Depends on npp_pkg for the divisor, numerator and step counter widths.
`timescale 1ns / 1ps

module npp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [npp_pkg::DIV_DEN_W-1:0]  rem_i,
  input  logic [npp_pkg::DIV_DEN_W-1:0]  den_i,
  input  logic [npp_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [npp_pkg::DIV_CNT_W-1:0]  steps_i,
  output logic                           done_o,
  output logic [npp_pkg::DIV_NUM_W-1:0]  quo_o
);
  import npp_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_NUM_W-1:0] num_q, quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q, done_q;

  // Bring down the next numerator bit
  assign rem_sh = {rem_q, num_q[DIV_NUM_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= steps_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      den_q <= den_i;
      num_q <= num_i;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= DIV_DEN_W'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/nearest_point_on_polyline.sv */
// Channel | Dir | Handshake   | Payload
// req_i   | in  | valid/ready | op, pos_x, pos_z, pos_height, last_vertex
// res_o   | out | valid/ready | found, distance, along, height, dir_x, dir_z
//
// A query request leaves the sequencer idle, and a first vertex goes straight to S_FINISH.
// A vertex that closes a segment runs the serial multiplier, square root and divider in
// turn: a nearer segment whose t needs the division runs every step, a clamped t skips
// S_DIV_T, a segment that is not nearer stops after S_SQRT_D and a short one after S_LEN_Z;
// a closing vertex adds S_EMIT. The units are shared, so the sequencer runs one at a time.
// Reset clears query, previous vertex, arc length and best entry; no sweep is needed. A
// stalled result waits in the output register; the next request is taken meanwhile, and a
// following result waits.
// Depends on npp_pkg, npp_if, npp_mul, npp_sqrt and npp_div.
`timescale 1ns / 1ps

module nearest_point_on_polyline (
  input  logic      clk_i,
  input  logic      rst_ni,
  npp_req_if.sink   req_i,
  npp_res_if.source res_o
);
  import npp_pkg::*;

  npp_state_e state_q, state_d;
  logic       launched_q;
  logic       mul_go, sqrt_go, div_go;

  // Model state
  logic signed [31:0] query_x_q, query_z_q, prev_x_q, prev_z_q, prev_h_q;
  logic               have_prev_q, best_found_q;
  logic [ALONG_W-1:0] acc_len_q, best_along_q;
  logic        [31:0] best_dist_q;
  logic signed [31:0] best_h_q;
  logic signed [15:0] best_dir_x_q, best_dir_z_q;

  // Per segment working registers
  logic signed [31:0] cur_x_q, cur_z_q, cur_h_q;
  logic               last_q, seg_q;
  logic [32:0]        dx_q, dz_q, wx_q, wz_q;
  logic [65:0]        len2_q;
  logic [66:0]        dot_q;
  logic [32:0]        len_q;
  logic [T_BITS:0]    t_q;
  logic [33:0]        ex_q, ez_q;
  logic [67:0]        err_q;

  npp_res_t res_q;
  logic     res_valid_q;

  logic req_fire, emit_fire;

  // Unit connections
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_prod;
  logic                 mul_done;
  logic [SQ_RAD_W-1:0]  sq_rad;
  logic [SQ_ROOT_W-1:0] sq_root;
  logic                 sq_done;
  logic [DIV_DEN_W-1:0] div_rem, div_den;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 div_done;

  // Derived values
  logic [31:0]        adx, adz, awx, awz, adh;
  logic [32:0]        dh;
  logic [33:0]        aex, aez;
  logic [65:0]        len2_new;
  logic [66:0]        prod67, dot_term, dot_new;
  logic               dot_le0, dot_ge;
  logic [67:0]        err_new, rnd;
  logic [37:0]        s_rnd;
  logic [31:0]        d_sat;
  logic               better;
  logic [44:0]        along_sum, acc_sum;
  logic [32:0]        h_sum;
  logic [DIV_NUM_W-1:0] num_x, num_z;
  logic [14:0]        dq;
  logic [15:0]        dir_val;

  assign req_fire  = req_i.valid && req_i.ready;
  assign emit_fire = (state_q == S_EMIT) && (!res_valid_q || res_o.ready);

  // Magnitudes of the segment, query offset and height step
  assign dh  = {cur_h_q[31], cur_h_q} - {prev_h_q[31], prev_h_q};
  assign adx = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
  assign adz = dz_q[32] ? 32'(-dz_q) : dz_q[31:0];
  assign awx = wx_q[32] ? 32'(-wx_q) : wx_q[31:0];
  assign awz = wz_q[32] ? 32'(-wz_q) : wz_q[31:0];
  assign adh = dh[32] ? 32'(-dh) : dh[31:0];
  assign aex = ex_q[33] ? -ex_q : ex_q;
  assign aez = ez_q[33] ? -ez_q : ez_q;

  // Accumulate squared length, dot product and squared error
  assign len2_new = ((state_q == S_LEN_X) ? '0 : len2_q) + mul_prod[65:0];
  assign prod67   = {1'b0, mul_prod[65:0]};
  assign dot_term = (((state_q == S_DOT_X) ? wx_q[32] ^ dx_q[32] : wz_q[32] ^ dz_q[32]))
                    ? -prod67 : prod67;
  assign dot_new  = ((state_q == S_DOT_X) ? '0 : dot_q) + dot_term;
  assign dot_le0  = dot_new[66] || (dot_new == '0);
  assign dot_ge   = dot_new[65:0] >= len2_q;
  assign err_new  = ((state_q == S_ERR_X) ? '0 : err_q) + mul_prod;

  // Round a product with t to nearest
  assign rnd   = mul_prod + (68'd1 << (T_BITS - 1));
  assign s_rnd = rnd[67:T_BITS];

  assign d_sat  = (|sq_root[33:32]) ? '1 : sq_root[31:0];
  assign better = !best_found_q || (d_sat < best_dist_q);

  assign along_sum = {1'b0, acc_len_q} + {7'b0, s_rnd};
  assign acc_sum   = {1'b0, acc_len_q} + {12'b0, len_q};
  assign h_sum     = dh[32] ? {prev_h_q[31], prev_h_q} - {1'b0, s_rnd[31:0]}
                            : {prev_h_q[31], prev_h_q} + {1'b0, s_rnd[31:0]};

  // Direction: round(|d| * 2^15 / len), saturated
  assign num_x   = {1'b0, adx, 15'b0} + {16'b0, len_q[32:1]};
  assign num_z   = {1'b0, adz, 15'b0} + {16'b0, len_q[32:1]};
  assign dq      = (div_quo > DIV_NUM_W'(DIR_MAX)) ? 15'(DIR_MAX) : div_quo[14:0];
  assign dir_val = (((state_q == S_DIR_X) ? dx_q[32] : dz_q[32])) ? -{1'b0, dq} : {1'b0, dq};

  // Operand selection for the shared units
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    sq_rad    = {2'b00, len2_q};
    div_rem   = '0;
    div_den   = {33'b0, len_q};
    div_num   = num_x;
    div_steps = DIV_CNT_W'(DIV_DIR_STEPS);
    case (state_q)
      S_LEN_X: begin mul_a = {2'b0, adx}; mul_b = {2'b0, adx}; end
      S_LEN_Z: begin mul_a = {2'b0, adz}; mul_b = {2'b0, adz}; end
      S_DOT_X: begin mul_a = {2'b0, awx}; mul_b = {2'b0, adx}; end
      S_DOT_Z: begin mul_a = {2'b0, awz}; mul_b = {2'b0, adz}; end
      S_OFF_X: begin mul_a = {2'b0, adx}; mul_b = {3'b0, t_q}; end
      S_OFF_Z: begin mul_a = {2'b0, adz}; mul_b = {3'b0, t_q}; end
      S_ERR_X: begin mul_a = aex; mul_b = aex; end
      S_ERR_Z: begin mul_a = aez; mul_b = aez; end
      S_ALONG: begin mul_a = {1'b0, len_q}; mul_b = {3'b0, t_q}; end
      S_HGT:   begin mul_a = {2'b0, adh}; mul_b = {3'b0, t_q}; end
      S_SQRT_D: sq_rad = err_q;
      S_DIV_T: begin
        div_rem   = dot_q[65:0];
        div_den   = len2_q;
        div_num   = '0;
        div_steps = DIV_CNT_W'(DIV_T_STEPS);
      end
      S_DIR_Z: div_num = num_z;
      default: ;
    endcase
  end

  // Next state and unit launches
  always_comb begin
    state_d = state_q;
    mul_go  = 1'b0;
    sqrt_go = 1'b0;
    div_go  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_fire && req_i.data.op) state_d = have_prev_q ? S_LEN_X : S_FINISH;
      end
      S_LEN_X: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_LEN_Z;
      end
      S_LEN_Z: begin
        mul_go = !launched_q;
        if (mul_done) state_d = (len2_new < 66'(SHORT_LEN2_LIM)) ? S_FINISH : S_SQRT_LEN;
      end
      S_SQRT_LEN: begin
        sqrt_go = !launched_q;
        if (sq_done) state_d = S_DOT_X;
      end
      S_DOT_X: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_DOT_Z;
      end
      S_DOT_Z: begin
        mul_go = !launched_q;
        if (mul_done) state_d = (dot_le0 || dot_ge) ? S_OFF_X : S_DIV_T;
      end
      S_DIV_T: begin
        div_go = !launched_q;
        if (div_done) state_d = S_OFF_X;
      end
      S_OFF_X: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_OFF_Z;
      end
      S_OFF_Z: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_ERR_X;
      end
      S_ERR_X: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_ERR_Z;
      end
      S_ERR_Z: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_SQRT_D;
      end
      S_SQRT_D: begin
        sqrt_go = !launched_q;
        if (sq_done) state_d = better ? S_ALONG : S_FINISH;
      end
      S_ALONG: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_HGT;
      end
      S_HGT: begin
        mul_go = !launched_q;
        if (mul_done) state_d = S_DIR_X;
      end
      S_DIR_X: begin
        div_go = !launched_q;
        if (div_done) state_d = S_DIR_Z;
      end
      S_DIR_Z: begin
        div_go = !launched_q;
        if (div_done) state_d = S_FINISH;
      end
      S_FINISH: state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register and launch flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_go || sqrt_go || div_go) begin
        launched_q <= 1'b1;
      end else if (mul_done || sq_done || div_done) begin
        launched_q <= 1'b0;
      end
    end
  end

  // Query, previous vertex, arc length and best entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q    <= '0;
      query_z_q    <= '0;
      prev_x_q     <= '0;
      prev_z_q     <= '0;
      prev_h_q     <= '0;
      have_prev_q  <= 1'b0;
      acc_len_q    <= '0;
      best_found_q <= 1'b0;
      best_dist_q  <= '0;
      best_along_q <= '0;
      best_h_q     <= '0;
      best_dir_x_q <= '0;
      best_dir_z_q <= '0;
    end else begin
      if ((req_fire && !req_i.data.op) || emit_fire) begin
        have_prev_q  <= 1'b0;
        acc_len_q    <= '0;
        best_found_q <= 1'b0;
        best_dist_q  <= '0;
        best_along_q <= '0;
        best_h_q     <= '0;
        best_dir_x_q <= '0;
        best_dir_z_q <= '0;
      end
      if (req_fire && !req_i.data.op) begin
        query_x_q <= req_i.data.pos_x;
        query_z_q <= req_i.data.pos_z;
      end
      // Take the nearer segment
      if (state_q == S_SQRT_D && sq_done && better) begin
        best_found_q <= 1'b1;
        best_dist_q  <= d_sat;
      end
      if (state_q == S_ALONG && mul_done) begin
        best_along_q <= along_sum[44] ? '1 : along_sum[ALONG_W-1:0];
      end
      if (state_q == S_HGT && mul_done) best_h_q <= h_sum[31:0];
      if (state_q == S_DIR_X && div_done) best_dir_x_q <= dir_val;
      if (state_q == S_DIR_Z && div_done) best_dir_z_q <= dir_val;
      // Advance to the new vertex
      if (state_q == S_FINISH) begin
        prev_x_q    <= cur_x_q;
        prev_z_q    <= cur_z_q;
        prev_h_q    <= cur_h_q;
        have_prev_q <= 1'b1;
        if (seg_q) acc_len_q <= acc_sum[44] ? '1 : acc_sum[ALONG_W-1:0];
      end
    end
  end

  // Segment working registers
  always_ff @(posedge clk_i) begin
    if (req_fire && req_i.data.op) begin
      cur_x_q <= req_i.data.pos_x;
      cur_z_q <= req_i.data.pos_z;
      cur_h_q <= req_i.data.pos_height;
      last_q  <= req_i.data.last_vertex;
      seg_q   <= 1'b0;
      dx_q    <= {req_i.data.pos_x[31], req_i.data.pos_x} - {prev_x_q[31], prev_x_q};
      dz_q    <= {req_i.data.pos_z[31], req_i.data.pos_z} - {prev_z_q[31], prev_z_q};
      wx_q    <= {query_x_q[31], query_x_q} - {prev_x_q[31], prev_x_q};
      wz_q    <= {query_z_q[31], query_z_q} - {prev_z_q[31], prev_z_q};
    end
    if ((state_q == S_LEN_X || state_q == S_LEN_Z) && mul_done) len2_q <= len2_new;
    if (state_q == S_LEN_Z && mul_done) seg_q <= !(len2_new < 66'(SHORT_LEN2_LIM));
    if (state_q == S_SQRT_LEN && sq_done) len_q <= sq_root[32:0];
    if ((state_q == S_DOT_X || state_q == S_DOT_Z) && mul_done) dot_q <= dot_new;
    // Clamp t at the segment ends
    if (state_q == S_DOT_Z && mul_done) begin
      if (dot_le0) begin
        t_q <= '0;
      end else if (dot_ge) begin
        t_q <= {1'b1, {T_BITS{1'b0}}};
      end
    end
    if (state_q == S_DIV_T && div_done) t_q <= {1'b0, div_quo[T_BITS-1:0]};
    if (state_q == S_OFF_X && mul_done) begin
      ex_q <= dx_q[32] ? {wx_q[32], wx_q} + s_rnd[33:0] : {wx_q[32], wx_q} - s_rnd[33:0];
    end
    if (state_q == S_OFF_Z && mul_done) begin
      ez_q <= dz_q[32] ? {wz_q[32], wz_q} + s_rnd[33:0] : {wz_q[32], wz_q} - s_rnd[33:0];
    end
    if ((state_q == S_ERR_X || state_q == S_ERR_Z) && mul_done) err_q <= err_new;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      res_q.found    <= best_found_q;
      res_q.distance <= best_dist_q;
      res_q.along    <= best_along_q;
      res_q.height   <= best_h_q;
      res_q.dir_x    <= best_dir_x_q;
      res_q.dir_z    <= best_dir_z_q;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  npp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  npp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  npp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .rem_i   (div_rem),
    .den_i   (div_den),
    .num_i   (div_num),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

endmodule

/* bench/npp_checker.sv */
// Checker for the nearest point on polyline block: watches both channels, predicts results.
// Depends on npp_pkg for payload types and npp_if for the channel interfaces.
`timescale 1ns / 1ps

module npp_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  npp_req_if    req_i,
  npp_res_if    res_i,
  output int    fail_cnt_o,
  output int    pending_o,
  output int    results_o
);
  import npp_pkg::*;

  localparam logic [63:0] T_ONE    = 64'd1 << T_BITS;
  localparam logic [63:0] ALONG_MX = (64'd1 << ALONG_W) - 1;
  localparam logic [63:0] DIST_MX  = 64'hFFFF_FFFF;

  // Shadow state of the block
  logic signed [63:0] qry_x, qry_z, last_x, last_z, last_h;
  logic               have_last;
  logic        [63:0] arc_len;
  logic               near_found;
  logic        [63:0] near_dist, near_along;
  logic signed [63:0] near_hgt, near_dx, near_dz;

  npp_res_t nearest_q[$];

  assign pending_o = nearest_q.size();

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cc;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c  = r | (64'd1 << i);
      cc = 128'(c) * 128'(c);
      if (cc <= v) r = c;
    end
    return r;
  endfunction

  // Round-to-nearest product d * t / 2^T_BITS, half away from zero
  function automatic logic signed [63:0] scale_by_t(logic signed [63:0] d, logic [63:0] t);
    logic [127:0] p;
    logic [63:0]  r;
    p = 128'(mag64(d)) * 128'(t) + 128'(T_ONE >> 1);
    r = 64'(p >> T_BITS);
    return d < 0 ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] unit_comp(logic signed [63:0] d, logic [63:0] len);
    logic [127:0] q;
    q = ((128'(mag64(d)) << 15) + 128'(len >> 1)) / 128'(len);
    if (q > 128'(DIR_MAX)) q = 128'(DIR_MAX);
    return d < 0 ? -$signed(64'(q)) : $signed(64'(q));
  endfunction

  function automatic void clear_line();
    have_last  = 1'b0;
    arc_len    = '0;
    near_found = 1'b0;
    near_dist  = '0;
    near_along = '0;
    near_hgt   = '0;
    near_dx    = '0;
    near_dz    = '0;
  endfunction

  // Project the query onto the segment from the last vertex to (bx, bz)
  function automatic void project_segment(logic signed [63:0] bx, logic signed [63:0] bz,
                                          logic signed [63:0] bh);
    logic signed [127:0] dx, dz, wx, wz, dotp;
    logic        [127:0] len2, dotu, e2;
    logic        [63:0]  len, t, d, a;
    logic signed [63:0]  ex, ez;
    dx = bx - last_x;
    dz = bz - last_z;
    wx = qry_x - last_x;
    wz = qry_z - last_z;
    len2 = 128'(dx * dx + dz * dz);
    // Skip segments shorter than a millimeter
    if (len2 < 128'(SHORT_LEN2_LIM)) return;
    len  = isqrt(len2);
    dotp = wx * dx + wz * dz;
    dotu = dotp;
    if (dotp <= 0) t = '0;
    else if (dotu >= len2) t = T_ONE;
    else t = 64'((dotu << T_BITS) / len2);
    ex = wx - scale_by_t(64'(dx), t);
    ez = wz - scale_by_t(64'(dz), t);
    e2 = 128'(mag64(ex)) * 128'(mag64(ex)) + 128'(mag64(ez)) * 128'(mag64(ez));
    d  = isqrt(e2);
    if (d > DIST_MX) d = DIST_MX;
    if (!near_found || d < near_dist) begin
      a = arc_len + 64'((128'(len) * 128'(t) + 128'(T_ONE >> 1)) >> T_BITS);
      near_found = 1'b1;
      near_dist  = d;
      near_along = a > ALONG_MX ? ALONG_MX : a;
      near_hgt   = last_h + scale_by_t(bh - last_h, t);
      near_dx    = unit_comp(64'(dx), len);
      near_dz    = unit_comp(64'(dz), len);
    end
    arc_len = arc_len + len;
    if (arc_len > ALONG_MX) arc_len = ALONG_MX;
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    npp_res_t exp_r;
    npp_res_t got;
    int       errs;
    errs = 0;
    if (!rst_ni) begin
      qry_x  = '0;
      qry_z  = '0;
      last_x = '0;
      last_z = '0;
      last_h = '0;
      clear_line();
      fail_cnt_o <= 0;
      results_o  <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = res_i.data;
        results_o <= results_o + 1;
        if (nearest_q.size() == 0) begin
          $error("unexpected result: found=%0d distance=%0h", got.found, got.distance);
          errs++;
        end else begin
          exp_r = nearest_q.pop_front();
          if (got.found !== exp_r.found) begin
            $error("found: expected %0d, got %0d", exp_r.found, got.found);
            errs++;
          end
          if (got.distance !== exp_r.distance) begin
            $error("distance: expected %0h, got %0h", exp_r.distance, got.distance);
            errs++;
          end
          if (got.along !== exp_r.along) begin
            $error("along: expected %0h, got %0h", exp_r.along, got.along);
            errs++;
          end
          if (got.height !== exp_r.height) begin
            $error("height: expected %0h, got %0h", exp_r.height, got.height);
            errs++;
          end
          if (got.dir_x !== exp_r.dir_x) begin
            $error("dir_x: expected %0h, got %0h", exp_r.dir_x, got.dir_x);
            errs++;
          end
          if (got.dir_z !== exp_r.dir_z) begin
            $error("dir_z: expected %0h, got %0h", exp_r.dir_z, got.dir_z);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
      if (req_i.valid && req_i.ready) begin
        if (req_i.data.op == 1'b0) begin
          qry_x = req_i.data.pos_x;
          qry_z = req_i.data.pos_z;
          clear_line();
        end else begin
          if (have_last)
            project_segment(req_i.data.pos_x, req_i.data.pos_z, req_i.data.pos_height);
          last_x    = req_i.data.pos_x;
          last_z    = req_i.data.pos_z;
          last_h    = req_i.data.pos_height;
          have_last = 1'b1;
          if (req_i.data.last_vertex) begin
            exp_r.found    = near_found;
            exp_r.distance = near_dist[31:0];
            exp_r.along    = near_along[ALONG_W-1:0];
            exp_r.height   = near_hgt[31:0];
            exp_r.dir_x    = near_dx[15:0];
            exp_r.dir_z    = near_dz[15:0];
            nearest_q = {nearest_q, exp_r};
            clear_line();
          end
        end
      end
    end
  end

endmodule

/* bench/tb_nearest_point_on_polyline.sv */
// Testbench top for nearest_point_on_polyline: directed and random polylines under idling and stalling.
// Depends on npp_pkg, npp_if, the block and npp_checker.
`timescale 1ns / 1ps

module tb_nearest_point_on_polyline;
  import npp_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int     PHASE_REQS  = 228;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt, pending, results;
  int   idle_pct, stall_pct;
  int   sent, lines;
  longint cycles;
  logic signed [31:0] prev_vx, prev_vz;

  npp_req_if req_i ();
  npp_res_if res_o ();

  nearest_point_on_polyline dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .res_o  (res_o)
  );

  npp_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .res_i      (res_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .results_o  (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    res_o.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive one request and hold it until accepted
  task automatic send_req(logic op, logic [31:0] x, logic [31:0] z, logic [31:0] h,
                          logic lst);
    logic fire;
    while ($urandom_range(99) < idle_pct) begin
      req_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_i.valid <= 1'b1;
    req_i.data  <= '{op: op, pos_x: x, pos_z: z, pos_height: h, last_vertex: lst};
    do begin
      @(negedge clk_i);
      fire = req_i.ready;
      @(posedge clk_i);
    end while (!fire);
    sent++;
    if (op) begin
      prev_vx = x;
      prev_vz = z;
    end
  endtask

  function automatic logic [31:0] wide_coord();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near_coord();
    return 32'($urandom_range(1 << 19)) - 32'(1 << 18);
  endfunction

  // Pick the next vertex: mostly nearby, some far, some a tiny step from the last
  task automatic send_vertex(logic lst);
    int sel;
    sel = $urandom_range(99);
    if (sel < 65)
      send_req(1'b1, near_coord(), near_coord(), $urandom, lst);
    else if (sel < 80)
      send_req(1'b1, wide_coord(), wide_coord(), wide_coord(), lst);
    else
      send_req(1'b1, prev_vx + 32'($urandom_range(6)) - 32'd3,
               prev_vz + 32'($urandom_range(6)) - 32'd3, $urandom, lst);
  endtask

  task automatic random_phase(int n);
    int nv;
    repeat (n) begin
      if ($urandom_range(99) < 15) begin
        // Noise: lone items, odd flags
        send_req(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(99) < 80)
          send_req(1'b0, near_coord(), near_coord(), $urandom, 1'($urandom_range(1)));
        else
          send_req(1'b0, wide_coord(), wide_coord(), $urandom, 1'($urandom_range(1)));
        nv = $urandom_range(1, 5);
        for (int i = 0; i < nv; i++) send_vertex(i == nv - 1);
        lines++;
      end
    end
  endtask

  initial begin
    idle_pct    = 0;
    stall_pct   = 0;
    sent        = 0;
    lines       = 0;
    cycles      = 0;
    prev_vx     = '0;
    prev_vz     = '0;
    rst_ni      = 1'b0;
    req_i.valid = 1'b0;
    req_i.data  = '0;
    res_o.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Vertices before any query use the origin
    send_req(1'b1, 32'h0000_1000, 32'h0000_2000, 32'h0000_0500, 1'b0);
    send_req(1'b1, 32'hFFFF_F000, 32'h0000_3000, 32'hFFFF_FB00, 1'b1);
    // Only a short segment: nothing found
    send_req(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1);
    send_req(1'b1, 32'h0000_5000, 32'h0000_5000, 32'h0000_0100, 1'b0);
    send_req(1'b1, 32'h0000_5002, 32'h0000_5001, 32'h0000_0200, 1'b1);
    // Lone last vertex
    send_req(1'b1, 32'h0, 32'h0, 32'h0, 1'b1);
    // Tie: query equidistant from two segments, first kept
    send_req(1'b0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_req(1'b1, 32'hFFFF_6000, 32'h0000_4000, 32'h0000_1000, 1'b0);
    send_req(1'b1, 32'h0000_A000, 32'h0000_4000, 32'h0000_2000, 1'b0);
    send_req(1'b1, 32'h0000_A000, 32'hFFFF_C000, 32'h8000_0000, 1'b0);
    send_req(1'b1, 32'hFFFF_6000, 32'hFFFF_C000, 32'h7FFF_FFFF, 1'b1);
    // Continue after the last vertex against the same query
    send_req(1'b1, 32'h0000_3000, 32'h0000_7000, 32'h0, 1'b0);
    send_req(1'b1, 32'h0000_9000, 32'hFFFF_1000, 32'h0, 1'b1);
    // Extreme coordinates, clamped projections on both ends
    send_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_req(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_req(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_req(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0);
    send_req(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_req(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
    // Axis-aligned segments, directions at full scale
    send_req(1'b0, 32'h0000_0800, 32'h0000_0800, 32'h0, 1'b0);
    send_req(1'b1, 32'h0, 32'h0, 32'h0, 1'b0);
    send_req(1'b1, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
    send_req(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1);

    random_phase(PHASE_REQS / 3);
    // Hold off until every result has drained
    req_i.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    idle_pct  = 87;
    random_phase(PHASE_REQS / 3);
    idle_pct  = 0;
    stall_pct = 87;
    random_phase(PHASE_REQS / 3);
    idle_pct  = 26;
    stall_pct = 26;
    random_phase(PHASE_REQS / 3);
    idle_pct  = 0;
    stall_pct = 0;
    random_phase(PHASE_REQS / 4);
    req_i.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    $display("Sent %0d requests over %0d random polylines; %0d results checked.",
             sent, lines, results);
    $display("Phases: free flow, sender idling, receiver stalling, both, and a drain pause.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/npp_pkg.sv
rtl/npp_if.sv
rtl/npp_mul.sv
rtl/npp_sqrt.sv
rtl/npp_div.sv
rtl/nearest_point_on_polyline.sv
bench/npp_checker.sv
bench/tb_nearest_point_on_polyline.sv
